// File: design/omni_wheel_odometry_macros.svh
// Assertion macros used by the bound checker omw_checker.
`ifndef OMNI_WHEEL_ODOMETRY_MACROS_SVH
`define OMNI_WHEEL_ODOMETRY_MACROS_SVH

// Implication into the next cycle, masked while reset is high.
`define OMW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication into the next cycle, checked during reset as well.
`define OMW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/omw_pkg.sv
`default_nettype none
package omw_pkg;

  localparam logic [31:0] LIN_GAIN_RESET = 32'd85899346;
  localparam logic [31:0] ANG_GAIN_RESET = 32'd419021200;
  localparam logic [31:0] SQRT3_HALF_Q32 = 32'd3719550787;
  localparam logic [31:0] TURNS_PER_RAD_Q32 = 32'd683565276;
  localparam logic signed [33:0] CORDIC_START_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam int CORDIC_STEPS = 30;

  localparam logic [1:0] CFG_LIN_GAIN = 2'd0;
  localparam logic [1:0] CFG_ANG_GAIN = 2'd1;

  typedef struct packed {
    logic               busy;
    logic signed [31:0] cos_val;
    logic signed [31:0] sin_val;
  } cordic_res_t;

  // Arctangent of 2^-i in binary-angle units.
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/omw_cordic.sv
`default_nettype none
module omw_cordic (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [31:0]         angle,
  output omw_pkg::cordic_res_t     res
);
  import omw_pkg::*;

  logic               busy;
  logic               fin;
  logic               flip;
  logic [4:0]         step;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic signed [31:0] cos_q;
  logic signed [31:0] sin_q;
  logic [31:0]        ang_red;
  logic               flip_in;
  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic signed [33:0] at;

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    logic signed [33:0] t;
    if (v > ONE_Q30) t = ONE_Q30;
    else if (v < -ONE_Q30) t = -ONE_Q30;
    else t = v;
    return t[31:0];
  endfunction

  always_comb begin
    flip_in = angle[31] ^ angle[30];
    ang_red = flip_in ? (angle ^ 32'h8000_0000) : angle;
    xf      = flip ? -x : x;
    yf      = flip ? -y : y;
    at      = signed'({2'b00, atan_turns(step)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      fin  <= 1'b0;
    end else if (busy && !fin) begin
      if (step == 5'(CORDIC_STEPS - 1)) fin <= 1'b1;
    end else if (fin) begin
      fin  <= 1'b0;
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip <= flip_in;
      x    <= CORDIC_START_Q30;
      y    <= '0;
      z    <= signed'({{2{ang_red[31]}}, ang_red});
      step <= '0;
    end else if (busy && !fin) begin
      if (z >= 0) begin
        x <= x - (y >>> step);
        y <= y + (x >>> step);
        z <= z - at;
      end else begin
        x <= x + (y >>> step);
        y <= y - (x >>> step);
        z <= z + at;
      end
      step <= step + 5'd1;
    end else if (fin) begin
      cos_q <= clamp_q30(xf);
      sin_q <= clamp_q30(yf);
    end
  end

  assign res.busy    = busy;
  assign res.cos_val = cos_q;
  assign res.sin_val = sin_q;

endmodule
`default_nettype wire

// File: design/omni_wheel_odometry.sv
`default_nettype none
// Three-wheel omni drive odometry.
// Input stream s_*: one word per wheel report (three wheel speeds, present
// mask, time step). A word whose mask is zero is taken and dropped: no result,
// no state change. Every other word yields one pose word on m_*.
// Config port cfg_*: write lin_gain (index 0) or ang_gain (index 1) while idle;
// other indexes are ignored.
// Eight multiply-and-round passes, each through states ML, MH, MA, MR and
// POST, run on one 33x33 multiplier; a rotation runs through states R0 to R5,
// and two 30-step CORDIC passes give sin/cos (heading, then half heading);
// the first CORDIC overlaps the velocity work.
// s_tready is high only while idle, so a new word is taken only after the last is through.
// Results wait in the output register; while m_tready is low the block still
// takes the next input word and stalls only when a new result is ready.
// Reset: position and heading clear, gains return to defaults, output empty.
module omni_wheel_odometry (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // wheel_speed_a, wheel_speed_b, wheel_speed_c, wheel_present, time_step, pad
  input  wire logic [135:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pos_x, pos_y, heading, orient_z, orient_w, body_vx, body_vy, body_vyaw
  output logic [255:0]      m_tdata
);
  import omw_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_ML     = 5'd1;
  localparam logic [4:0] ST_MH     = 5'd2;
  localparam logic [4:0] ST_MA     = 5'd3;
  localparam logic [4:0] ST_MR     = 5'd4;
  localparam logic [4:0] ST_POST   = 5'd5;
  localparam logic [4:0] ST_WAITC  = 5'd6;
  localparam logic [4:0] ST_R0     = 5'd7;
  localparam logic [4:0] ST_R1     = 5'd8;
  localparam logic [4:0] ST_R2     = 5'd9;
  localparam logic [4:0] ST_R3     = 5'd10;
  localparam logic [4:0] ST_R4     = 5'd11;
  localparam logic [4:0] ST_R5     = 5'd12;
  localparam logic [4:0] ST_QSTART = 5'd13;
  localparam logic [4:0] ST_QWAIT  = 5'd14;
  localparam logic [4:0] ST_OUT    = 5'd15;

  localparam logic [2:0] OP_T1  = 3'd0;
  localparam logic [2:0] OP_VX  = 3'd1;
  localparam logic [2:0] OP_VY  = 3'd2;
  localparam logic [2:0] OP_VW  = 3'd3;
  localparam logic [2:0] OP_PX  = 3'd4;
  localparam logic [2:0] OP_PY  = 3'd5;
  localparam logic [2:0] OP_E   = 3'd6;
  localparam logic [2:0] OP_TRN = 3'd7;

  localparam logic [1:0] SH16 = 2'd0;
  localparam logic [1:0] SH24 = 2'd1;
  localparam logic [1:0] SH32 = 2'd2;
  localparam logic [1:0] SH33 = 2'd3;

  logic [4:0]         state;
  logic [31:0]        lin_gain;
  logic [31:0]        ang_gain;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic [31:0]        heading_angle;

  logic signed [34:0] opa_vy;
  logic signed [33:0] opa_sum;
  logic [31:0]        dt;
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [31:0] vw;
  logic signed [33:0] rx;
  logic signed [33:0] ry;
  logic signed [63:0] rot;

  logic               mr_sign;
  logic [47:0]        mr_mag;
  logic [31:0]        mr_gain;
  logic [1:0]         mr_sh;
  logic [2:0]         op;
  logic [79:0]        acc;
  logic signed [55:0] rnd;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;

  logic [79:0]        mr_half;
  logic [79:0]        mr_sum;
  logic [55:0]        mr_q;
  logic signed [55:0] rnd_next;

  logic               accept;
  logic signed [31:0] wa;
  logic signed [31:0] wb;
  logic signed [31:0] wc;
  logic signed [32:0] in_dif;
  logic signed [34:0] in_vy;
  logic signed [33:0] in_sum;
  logic [2:0]         in_present;

  logic               cor_start;
  logic [31:0]        cor_angle;
  cordic_res_t        cor;

  logic signed [55:0] px_sum;
  logic signed [55:0] py_sum;
  logic signed [63:0] rot_rnd;

  function automatic logic [47:0] mag48(input logic signed [55:0] v);
    logic [55:0] t;
    t = v[55] ? 56'(-v) : 56'(v);
    return t[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
    logic signed [31:0] r;
    if (v > 56'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -56'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Ties away from zero: bias by half, one less for negative values.
  function automatic logic signed [33:0] round30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + (v[63] ? 64'sd536870911 : 64'sd536870912);
    t = t >>> 30;
    return t[33:0];
  endfunction

  omw_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .res   (cor)
  );

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign in_present = s_tdata[98:96];
  assign wa         = in_present[0] ? signed'(s_tdata[31:0])  : 32'sd0;
  assign wb         = in_present[1] ? signed'(s_tdata[63:32]) : 32'sd0;
  assign wc         = in_present[2] ? signed'(s_tdata[95:64]) : 32'sd0;
  assign in_dif     = 33'(wc) - 33'(wb);
  assign in_vy      = (35'(wa) <<< 1) - 35'(wb) - 35'(wc);
  assign in_sum     = 34'(wa) + 34'(wb) + 34'(wc);

  assign cor_start  = (accept && (in_present != 3'b000)) || (state == ST_QSTART);
  assign cor_angle  = (state == ST_QSTART) ? (heading_angle >> 1) : heading_angle;

  always_comb begin
    unique case (state)
      ST_ML: begin
        mul_a = signed'({1'b0, mr_mag[31:0]});
        mul_b = signed'({1'b0, mr_gain});
      end
      ST_MH: begin
        mul_a = signed'({17'd0, mr_mag[47:32]});
        mul_b = signed'({1'b0, mr_gain});
      end
      ST_R0: begin
        mul_a = 33'(vx);
        mul_b = 33'(cor.cos_val);
      end
      ST_R1: begin
        mul_a = 33'(vy);
        mul_b = 33'(cor.sin_val);
      end
      ST_R2: begin
        mul_a = 33'(vx);
        mul_b = 33'(cor.sin_val);
      end
      ST_R3: begin
        mul_a = 33'(vy);
        mul_b = 33'(cor.cos_val);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (mr_sh)
      SH16: mr_half = 80'd1 << 15;
      SH24: mr_half = 80'd1 << 23;
      SH32: mr_half = 80'd1 << 31;
      SH33: mr_half = 80'd1 << 32;
    endcase
    mr_sum = acc + mr_half;
    unique case (mr_sh)
      SH16: mr_q = mr_sum[71:16];
      SH24: mr_q = mr_sum[79:24];
      SH32: mr_q = {8'd0, mr_sum[79:32]};
      SH33: mr_q = {9'd0, mr_sum[79:33]};
    endcase
    rnd_next = mr_sign ? -signed'(mr_q) : signed'(mr_q);
    px_sum   = 56'(world_x) + rnd;
    py_sum   = 56'(world_y) + rnd;
    rot_rnd  = rot + prod[63:0];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_gain <= LIN_GAIN_RESET;
      ang_gain <= ANG_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIN_GAIN: lin_gain <= cfg_data;
        CFG_ANG_GAIN: ang_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      world_x       <= '0;
      world_y       <= '0;
      heading_angle <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_OUT)) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && (in_present != 3'b000)) begin
            opa_vy  <= in_vy;
            opa_sum <= in_sum;
            dt      <= s_tdata[130:99];
            mr_sign <= in_dif[32];
            mr_mag  <= mag48(56'(in_dif));
            mr_gain <= SQRT3_HALF_Q32;
            mr_sh   <= SH32;
            op      <= OP_T1;
            state   <= ST_ML;
          end
        end
        ST_ML: state <= ST_MH;
        ST_MH: begin
          acc   <= {16'd0, prod[63:0]};
          state <= ST_MA;
        end
        ST_MA: begin
          acc   <= acc + {prod[47:0], 32'd0};
          state <= ST_MR;
        end
        ST_MR: begin
          rnd   <= rnd_next;
          state <= ST_POST;
        end
        ST_POST: begin
          state <= (op == OP_VW) ? ST_WAITC : (op == OP_TRN) ? ST_QSTART : ST_ML;
          unique case (op)
            OP_T1: begin
              mr_sign <= rnd[55];
              mr_mag  <= mag48(rnd);
              mr_gain <= lin_gain;
              mr_sh   <= SH32;
              op      <= OP_VX;
            end
            OP_VX: begin
              vx      <= sat32(rnd);
              mr_sign <= opa_vy[34];
              mr_mag  <= mag48(56'(opa_vy));
              mr_gain <= lin_gain;
              mr_sh   <= SH33;
              op      <= OP_VY;
            end
            OP_VY: begin
              vy      <= sat32(rnd);
              mr_sign <= opa_sum[33];
              mr_mag  <= mag48(56'(opa_sum));
              mr_gain <= ang_gain;
              mr_sh   <= SH32;
              op      <= OP_VW;
            end
            OP_VW: begin
              vw <= sat32(rnd);
            end
            OP_PX: begin
              world_x <= sat32(px_sum);
              mr_sign <= ry[33];
              mr_mag  <= mag48(56'(ry));
              mr_gain <= dt;
              mr_sh   <= SH24;
              op      <= OP_PY;
            end
            OP_PY: begin
              world_y <= sat32(py_sum);
              mr_sign <= vw[31];
              mr_mag  <= mag48(56'(vw));
              mr_gain <= dt;
              mr_sh   <= SH16;
              op      <= OP_E;
            end
            OP_E: begin
              mr_sign <= rnd[55];
              mr_mag  <= mag48(rnd);
              mr_gain <= TURNS_PER_RAD_Q32;
              mr_sh   <= SH24;
              op      <= OP_TRN;
            end
            OP_TRN: begin
              heading_angle <= heading_angle + rnd[31:0];
            end
          endcase
        end
        ST_WAITC: begin
          if (!cor.busy) state <= ST_R0;
        end
        ST_R0: state <= ST_R1;
        ST_R1: begin
          rot   <= prod[63:0];
          state <= ST_R2;
        end
        ST_R2: begin
          rot   <= rot - prod[63:0];
          state <= ST_R3;
        end
        ST_R3: begin
          rx    <= round30(rot);
          rot   <= prod[63:0];
          state <= ST_R4;
        end
        ST_R4: begin
          rot   <= rot_rnd;
          state <= ST_R5;
        end
        ST_R5: begin
          ry      <= round30(rot);
          mr_sign <= rx[33];
          mr_mag  <= mag48(56'(rx));
          mr_gain <= dt;
          mr_sh   <= SH24;
          op      <= OP_PX;
          state   <= ST_ML;
        end
        ST_QSTART: state <= ST_QWAIT;
        ST_QWAIT: begin
          if (!cor.busy) state <= ST_OUT;
        end
        ST_OUT: begin
          // hold the finished pose until the output register frees up
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {vw, vy, vx, cor.cos_val, cor.sin_val, heading_angle,
                         world_y, world_x};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/omw_checker.sv
`default_nettype none
`include "omni_wheel_odometry_macros.svh"
module omw_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic [135:0] s_tdata,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [255:0] m_tdata
);
  `OMW_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
  `OMW_ASSERT_NEXT(a_busy_after_word, clk, rst, s_tvalid && s_tready && (s_tdata[98:96] != 3'b000), !s_tready, "input still ready after a word with wheels")
  `OMW_ASSERT_NEXT(a_drop_empty, clk, rst, s_tvalid && s_tready && (s_tdata[98:96] == 3'b000), s_tready, "word with no wheels did not drop")
  `OMW_ASSERT_NEXT_ALWAYS(a_reset_state, clk, rst, !m_tvalid && s_tready, "block not idle after reset")
endmodule

bind omni_wheel_odometry omw_checker u_omw_checker (.*);
`default_nettype wire

// File: bench/omni_wheel_odometry_checker.sv
`timescale 1ns / 100ps
module omni_wheel_odometry_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [135:0] s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [255:0] m_tdata,
  output int                errors,
  output int                pending
);
  import omw_pkg::*;

  logic [31:0]  lin_gain_q;
  logic [31:0]  ang_gain_q;
  logic [31:0]  pos_x_q;
  logic [31:0]  pos_y_q;
  logic [31:0]  heading_q;
  logic [255:0] pose_queue[$];

  string field_names[8] = '{"pos_x", "pos_y", "heading", "orient_z", "orient_w",
                            "body_vx", "body_vy", "body_vyaw"};

  assign pending = pose_queue.size();

  task automatic report(input string what);
    $display("%0t ERROR %s", $time, what);
    errors++;
  endtask

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round(a * g / 2^sh), ties away from zero on the magnitude
  function automatic longint scale_round(input longint a, input logic [31:0] g, input int sh);
    logic [63:0]  mag;
    logic [127:0] p;
    longint       q;
    mag = (a < 0) ? -a : a;
    p = {64'b0, mag} * {96'b0, g};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    q = longint'({1'b0, p[62:0]});
    return (a < 0) ? -q : q;
  endfunction

  function automatic void sin_cos(input logic [31:0] ang, output longint c, output longint s);
    logic   flip;
    longint x, y, z, nx;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang - 32'h80000000;
    z = longint'($signed(ang));
    x = longint'(CORDIC_START_Q30);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(atan_turns(i[4:0]));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(atan_turns(i[4:0]));
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x > ONE_Q30) ? ONE_Q30 : (x < -ONE_Q30) ? -ONE_Q30 : x;
    s = (y > ONE_Q30) ? ONE_Q30 : (y < -ONE_Q30) ? -ONE_Q30 : y;
  endfunction

  task automatic advance_pose(input logic [135:0] w);
    logic [2:0]  mask;
    logic [31:0] dt;
    longint      wa, wb, wc, vx, vy, vw, c, s, rx, ry, e, turn, qz, qw;
    mask = w[98:96];
    dt = w[130:99];
    // drop words with no wheel present
    if (mask == 3'd0) return;
    wa = mask[0] ? longint'($signed(w[31:0])) : 0;
    wb = mask[1] ? longint'($signed(w[63:32])) : 0;
    wc = mask[2] ? longint'($signed(w[95:64])) : 0;
    vx = clip32(scale_round(scale_round(wc - wb, SQRT3_HALF_Q32, 32), lin_gain_q, 32));
    vy = clip32(scale_round(2 * wa - wb - wc, lin_gain_q, 33));
    vw = clip32(scale_round(wa + wb + wc, ang_gain_q, 32));
    sin_cos(heading_q, c, s);
    rx = scale_round(vx * c - vy * s, 32'd1, 30);
    ry = scale_round(vx * s + vy * c, 32'd1, 30);
    pos_x_q = 32'(clip32(longint'($signed(pos_x_q)) + scale_round(rx, dt, 24)));
    pos_y_q = 32'(clip32(longint'($signed(pos_y_q)) + scale_round(ry, dt, 24)));
    e = scale_round(vw, dt, 16);
    turn = scale_round(e, TURNS_PER_RAD_Q32, 24);
    heading_q = heading_q + 32'(turn);
    sin_cos({1'b0, heading_q[31:1]}, qw, qz);
    pose_queue.insert(pose_queue.size(), {32'(vw), 32'(vy), 32'(vx), 32'(qw), 32'(qz),
                                          heading_q, pos_y_q, pos_x_q});
  endtask

  always @(posedge clk) begin
    logic [255:0] want;
    if (rst) begin
      lin_gain_q = LIN_GAIN_RESET;
      ang_gain_q = ANG_GAIN_RESET;
      pos_x_q = '0;
      pos_y_q = '0;
      heading_q = '0;
      pose_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LIN_GAIN) lin_gain_q = cfg_data;
        else if (cfg_index == CFG_ANG_GAIN) ang_gain_q = cfg_data;
      end
      if (s_tvalid && s_tready) advance_pose(s_tdata);
      if (m_tvalid && m_tready) begin
        if (pose_queue.size() == 0) begin
          report("pose word with nothing expected");
        end else begin
          want = pose_queue.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (m_tdata[k*32 +: 32] !== want[k*32 +: 32])
              report($sformatf("%s got %h want %h", field_names[k],
                               m_tdata[k*32 +: 32], want[k*32 +: 32]));
          end
        end
      end
    end
  end
endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import omw_pkg::*;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  // wheel_speed_a, wheel_speed_b, wheel_speed_c, wheel_present, time_step, pad
  logic [135:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // pos_x, pos_y, heading, orient_z, orient_w, body_vx, body_vy, body_vyaw
  logic [255:0] m_tdata;
  int           errors;
  int           pending;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_req;
  bit           hold_done;
  int           hold_cnt;
  longint       cycles;

  omni_wheel_odometry u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  omni_wheel_odometry_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 64'd1500000) begin
        $display("omni_wheel_odometry regression: fail");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 0;
    hold_cnt = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_cnt = 600;
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_word(input logic [31:0] wa, input logic [31:0] wb,
                           input logic [31:0] wc, input logic [2:0] mask,
                           input logic [31:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {5'b0, dt, mask, wc, wb, wa};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // wait for all pose words, then keep the input idle before the next segment
  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_speed();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(32'h3FFFFF)) - 32'sh200000);
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(19))
      0: return $urandom;
      1: return 32'd0;
      default: return $urandom_range(32'h200000);
    endcase
  endfunction

  initial begin
    logic [31:0] gains[6][2];
    rst = 1;
    cfg_we = 0;
    cfg_index = CFG_LIN_GAIN;
    cfg_data = '0;
    s_tvalid = 0;
    s_tdata = '0;
    hold_req = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every mask, zero step, extremes, saturation, wrap
    for (int m = 0; m < 8; m++)
      send_word(32'h00012345, 32'hFFFE8000, 32'h00030000, m[2:0], 32'h00100000);
    send_word(32'h00010000, 32'h00010000, 32'h00010000, 3'd7, 32'd0);
    send_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 3'd7, 32'hFFFFFFFF);
    send_word(32'h80000000, 32'h80000000, 32'h80000000, 3'd7, 32'hFFFFFFFF);
    send_word(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 3'd7, 32'hFFFFFFFF);
    send_word(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 3'd7, 32'hFFFFFFFF);
    send_word(32'h7FFFFFFF, 32'h80000000, 32'h00000000, 3'd3, 32'hFFFFFFFF);
    send_word(32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 3'd5, 32'h00000001);
    send_word(32'h00000000, 32'h00000000, 32'h00000000, 3'd7, 32'hFFFFFFFF);
    for (int k = 0; k < 6; k++)
      send_word(32'h01000000, 32'h01000000, 32'h01000000, 3'd7, 32'h08000000);
    drain();

    gains[0] = '{32'hFFFFFFFF, 32'hFFFFFFFF};
    gains[1] = '{32'h00000000, 32'h00000000};
    gains[2] = '{$urandom, $urandom};
    gains[3] = '{32'hFFFFFFFF, 32'h00000001};
    gains[4] = '{$urandom, $urandom};
    gains[5] = '{LIN_GAIN_RESET, ANG_GAIN_RESET};
    for (int seg = 0; seg < 6; seg++) begin
      write_reg(CFG_LIN_GAIN, gains[seg][0]);
      write_reg(CFG_ANG_GAIN, gains[seg][1]);
      // out-of-range indexes are ignored
      write_reg(2'd2 + 2'($urandom_range(1)), $urandom);
      case (seg / 2)
        0: begin send_idle_pct = 15; recv_idle_pct = 70; end
        1: begin send_idle_pct = 70; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < 290; n++) begin
        if (seg == 4 && n == 20) hold_req = 1;
        send_word(rand_speed(), rand_speed(), rand_speed(),
                  ($urandom_range(11) == 0) ? 3'd0 : 3'($urandom_range(1, 7)),
                  rand_step());
      end
      drain();
    end

    if (errors == 0) begin
      $display("omni_wheel_odometry regression: pass");
    end else begin
      $display("omni_wheel_odometry regression: fail");
    end
    $finish;
  end
endmodule
